/* rtl/core/ppf_pkg.sv */
// ----------------------------------------------------------------------------
// ppf_pkg
// Shared types and constants of the printer packet framer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppf_pkg;

  localparam int unsigned MAX_PAYLOAD = 640;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] MAGIC_0       = 8'h88;
  localparam logic [7:0] MAGIC_1       = 8'h33;
  localparam logic [7:0] FILL_BYTE     = 8'h00;
  localparam logic [7:0] STATUS_ABSENT = 8'hFF;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_PAYLOAD = 2'd1,
    OP_RX      = 2'd2,
    OP_FAIL    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    RES_TX     = 2'd0,
    RES_STATUS = 2'd1,
    RES_ERROR  = 2'd2,
    RES_ABORT  = 2'd3
  } res_kind_e;

  typedef enum logic [2:0] {
    RUN_ERROR,
    RUN_ABORT,
    RUN_STATUS,
    RUN_PAYLOAD,
    RUN_HEADER
  } run_kind_e;

  // One queued run: everything the back end needs to expand an item's results
  typedef struct packed {
    run_kind_e   kind;
    logic [7:0]  data;
    logic [9:0]  len;
    logic [15:0] sum;
    logic        trailer;
  } run_t;

endpackage

`default_nettype wire

/* rtl/core/ppf_front.sv */
// ----------------------------------------------------------------------------
// ppf_front
// Packet sequencer: tracks phase, length and checksum, and turns each
// accepted item, bar a first received byte, into one run descriptor for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppf_front import ppf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [1:0] opcode_i,
  input  wire logic [7:0] command_i,
  input  wire logic [9:0] payload_length_i,
  input  wire logic [7:0] data_byte_i,
  output logic            run_valid_o,
  output run_t            run_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PAYLOAD,
    PH_RX1,
    PH_RX2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [9:0]  remain_q, remain_d;
  logic [15:0] sum_q, sum_d;
  logic [15:0] seed;
  logic [15:0] sum_add;
  opcode_e     op;

  assign op      = opcode_e'(opcode_i);
  assign seed    = {8'h00, command_i} + {8'h00, payload_length_i[7:0]}
                 + {14'h0, payload_length_i[9:8]};
  assign sum_add = sum_q + {8'h00, data_byte_i};

  always_comb begin
    phase_d       = phase_q;
    remain_d      = remain_q;
    sum_d         = sum_q;
    run_valid_o   = 1'b0;
    run_o.kind    = RUN_ERROR;
    run_o.data    = data_byte_i;
    run_o.len     = payload_length_i;
    run_o.sum     = sum_q;
    run_o.trailer = 1'b0;
    if (accept_i) begin
      case (op)
        OP_START: begin
          run_valid_o = 1'b1;
          if (phase_q == PH_IDLE && payload_length_i <= 10'(MAX_PAYLOAD)) begin
            run_o.kind    = RUN_HEADER;
            run_o.data    = command_i;
            run_o.sum     = seed;
            run_o.trailer = (payload_length_i == 10'd0);
            remain_d      = payload_length_i;
            sum_d         = seed;
            phase_d       = (payload_length_i == 10'd0) ? PH_RX1 : PH_PAYLOAD;
          end
        end
        OP_PAYLOAD: begin
          run_valid_o = 1'b1;
          if (phase_q == PH_PAYLOAD && remain_q != 10'd0) begin
            run_o.kind    = RUN_PAYLOAD;
            run_o.sum     = sum_add;
            run_o.trailer = (remain_q == 10'd1);
            remain_d      = remain_q - 10'd1;
            sum_d         = sum_add;
            if (remain_q == 10'd1) begin
              phase_d = PH_RX1;
            end
          end
        end
        OP_RX: begin
          case (phase_q)
            PH_RX1: begin
              phase_d = PH_RX2;
            end
            PH_RX2: begin
              run_valid_o = 1'b1;
              run_o.kind  = RUN_STATUS;
              phase_d     = PH_IDLE;
            end
            default: begin
              run_valid_o = 1'b1;
            end
          endcase
        end
        default: begin
          run_valid_o = 1'b1;
          run_o.kind  = RUN_ABORT;
          phase_d     = PH_IDLE;
          remain_d    = 10'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      remain_q <= '0;
      sum_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      remain_q <= remain_d;
      sum_q    <= sum_d;
    end
  end

  a_payload_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> remain_q != 10'd0)
    else $error("payload phase with no bytes left");

  a_len_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    remain_q <= 10'(MAX_PAYLOAD))
    else $error("remaining count above limit");

endmodule

`default_nettype wire

/* rtl/core/ppf_queue.sv */
// ----------------------------------------------------------------------------
// ppf_queue
// Short FIFO of run descriptors between sequencer and byte emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppf_queue import ppf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_i,
  input  run_t      wr_data_i,
  output logic      full_o,
  input  wire logic rd_i,
  output logic      valid_o,
  output run_t      rd_data_o
);

  run_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_wr, do_rd;

  assign full_o    = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o   = (count_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count_q <= count_q + QCNT_W'(1);
        2'b01:   count_q <= count_q - QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count overflow");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    QPTR_W'(wr_ptr_q - rd_ptr_q) == QPTR_W'(count_q))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

/* rtl/core/ppf_back.sv */
// ----------------------------------------------------------------------------
// ppf_back
// Byte emitter: expands each run descriptor into its result transfers,
// one per cycle into the output register while it is empty or being popped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppf_back import ppf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       run_valid_i,
  input  run_t            run_i,
  output logic            run_pop_o,
  output logic            empty,
  input  wire logic       pop,
  output logic [1:0]      result_kind_o,
  output logic [7:0]      tx_byte_o,
  output logic [7:0]      status_byte_o,
  output logic            printer_present_o,
  output logic            last_of_run_o
);

  localparam logic [3:0] LastStepMax = 4'd9;

  logic       out_valid_q;
  res_kind_e  kind_q, kind_d;
  logic [7:0] tx_q, tx_d;
  logic [7:0] status_q, status_d;
  logic       present_q, present_d;
  logic       last_q, last_d;
  logic [3:0] step_q;
  logic [3:0] last_step;
  logic       adv, emit;

  function automatic logic [7:0] trailer_byte(logic [15:0] sum, logic [3:0] idx);
    case (idx)
      4'd0:    return sum[7:0];
      4'd1:    return sum[15:8];
      default: return FILL_BYTE;
    endcase
  endfunction

  assign adv  = !out_valid_q || pop;
  assign emit = adv && run_valid_i;

  always_comb begin
    kind_d    = RES_ERROR;
    tx_d      = 8'h00;
    status_d  = 8'h00;
    present_d = 1'b0;
    last_step = 4'd0;
    case (run_i.kind)
      RUN_HEADER: begin
        kind_d    = RES_TX;
        last_step = run_i.trailer ? 4'd9 : 4'd5;
        case (step_q)
          4'd0:    tx_d = MAGIC_0;
          4'd1:    tx_d = MAGIC_1;
          4'd2:    tx_d = run_i.data;
          4'd3:    tx_d = FILL_BYTE;
          4'd4:    tx_d = run_i.len[7:0];
          4'd5:    tx_d = {6'h00, run_i.len[9:8]};
          default: tx_d = trailer_byte(run_i.sum, step_q - 4'd6);
        endcase
      end
      RUN_PAYLOAD: begin
        kind_d    = RES_TX;
        last_step = run_i.trailer ? 4'd4 : 4'd0;
        tx_d      = (step_q == 4'd0) ? run_i.data
                                     : trailer_byte(run_i.sum, step_q - 4'd1);
      end
      RUN_STATUS: begin
        kind_d    = RES_STATUS;
        status_d  = run_i.data;
        present_d = (run_i.data != STATUS_ABSENT);
      end
      RUN_ABORT: begin
        kind_d = RES_ABORT;
      end
      default: begin
        kind_d = RES_ERROR;
      end
    endcase
    last_d = (step_q == last_step);
  end

  assign run_pop_o = emit && last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        step_q      <= last_d ? 4'd0 : step_q + 4'd1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q    <= kind_d;
      tx_q      <= tx_d;
      status_q  <= status_d;
      present_q <= present_d;
      last_q    <= last_d;
    end
  end

  assign empty             = !out_valid_q;
  assign result_kind_o     = kind_q;
  assign tx_byte_o         = tx_q;
  assign status_byte_o     = status_q;
  assign printer_present_o = present_q;
  assign last_of_run_o     = last_q;

  a_step_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= LastStepMax)
    else $error("emitter step out of range");

  a_step_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != 4'd0 |-> run_valid_i)
    else $error("run left queue mid expansion");

endmodule

`default_nettype wire

/* rtl/core/printer_packet_framer.sv */
// ----------------------------------------------------------------------------
// printer_packet_framer
// Frames printer packets (magic header, command, length, payload, 16-bit
// additive checksum, keepalive) and reports the printer status reply.
// ----------------------------------------------------------------------------
// Path: an item's first result reaches the outputs through the run queue and the
//   output register; further results of the same item follow one per cycle while pop
//   is held. Throughput: one item in per cycle while the 4-entry run queue has room;
//   one result out per cycle while pop is held. A valid start yields 6 results (10
//   for an empty packet), the last payload byte 5, a first received byte none, every
//   other item 1.
// Reset: rst_ni clears phase, counters, queue and output valid at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module printer_packet_framer import ppf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] opcode_i,
  input  wire logic [7:0] command_i,
  input  wire logic [9:0] payload_length_i,
  input  wire logic [7:0] data_byte_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [1:0]      result_kind_o,
  output logic [7:0]      tx_byte_o,
  output logic [7:0]      status_byte_o,
  output logic            printer_present_o,
  output logic            last_of_run_o
);

  logic accept;
  logic run_wr;
  run_t run_wr_data;
  logic q_full;
  logic q_valid;
  run_t q_data;
  logic q_pop;

  assign full   = q_full;
  assign accept = push && !q_full;

  ppf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .opcode_i         (opcode_i),
    .command_i        (command_i),
    .payload_length_i (payload_length_i),
    .data_byte_i      (data_byte_i),
    .run_valid_o      (run_wr),
    .run_o            (run_wr_data)
  );

  ppf_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (run_wr),
    .wr_data_i (run_wr_data),
    .full_o    (q_full),
    .rd_i      (q_pop),
    .valid_o   (q_valid),
    .rd_data_o (q_data)
  );

  ppf_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .run_valid_i       (q_valid),
    .run_i             (q_data),
    .run_pop_o         (q_pop),
    .empty             (empty),
    .pop               (pop),
    .result_kind_o     (result_kind_o),
    .tx_byte_o         (tx_byte_o),
    .status_byte_o     (status_byte_o),
    .printer_present_o (printer_present_o),
    .last_of_run_o     (last_of_run_o)
  );

endmodule

`default_nettype wire

/* dv/ppf_framer_checker.sv */
// ----------------------------------------------------------------------------
// ppf_framer_checker
// Watches both queue ports of the printer packet framer, predicts the result
// stream of every accepted item and compares each popped result against the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppf_framer_checker import ppf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  input  logic       full,
  input  logic [1:0] opcode_i,
  input  logic [7:0] command_i,
  input  logic [9:0] payload_length_i,
  input  logic [7:0] data_byte_i,
  input  logic       empty,
  input  logic       pop,
  input  logic [1:0] result_kind_i,
  input  logic [7:0] tx_byte_i,
  input  logic [7:0] status_byte_i,
  input  logic       printer_present_i,
  input  logic       last_of_run_i,
  output int         mismatch_count_o,
  output int         outstanding_o
);

  typedef enum logic [1:0] {
    LINK_IDLE,
    LINK_PAYLOAD,
    LINK_RX1,
    LINK_RX2
  } link_phase_e;

  typedef struct packed {
    res_kind_e  kind;
    logic [7:0] tx;
    logic [7:0] status;
    logic       present;
    logic       last;
  } framer_result_t;

  framer_result_t expected_results_q[$];
  framer_result_t want;
  link_phase_e    link_phase;
  logic [9:0]     bytes_left;
  logic [15:0]    checksum;
  int             errors;

  function automatic void add_result(res_kind_e kind, logic [7:0] tx, logic [7:0] st,
                                     logic pres);
    framer_result_t r;
    r = '{kind: kind, tx: tx, status: st, present: pres, last: 1'b0};
    expected_results_q.push_back(r);
  endfunction

  function automatic void add_trailer();
    add_result(RES_TX, checksum[7:0], 8'h00, 1'b0);
    add_result(RES_TX, checksum[15:8], 8'h00, 1'b0);
    add_result(RES_TX, FILL_BYTE, 8'h00, 1'b0);
    add_result(RES_TX, FILL_BYTE, 8'h00, 1'b0);
    link_phase = LINK_RX1;
  endfunction

  function automatic void frame_item(opcode_e op, logic [7:0] cmd, logic [9:0] len,
                                     logic [7:0] db);
    int queued;
    queued = expected_results_q.size();
    case (op)
      OP_START: begin
        if (link_phase != LINK_IDLE || len > MAX_PAYLOAD) begin
          add_result(RES_ERROR, 8'h00, 8'h00, 1'b0);
        end else begin
          bytes_left  = len;
          checksum    = 16'(cmd) + 16'(len[7:0]) + 16'(len[9:8]);
          add_result(RES_TX, MAGIC_0, 8'h00, 1'b0);
          add_result(RES_TX, MAGIC_1, 8'h00, 1'b0);
          add_result(RES_TX, cmd, 8'h00, 1'b0);
          add_result(RES_TX, FILL_BYTE, 8'h00, 1'b0);
          add_result(RES_TX, len[7:0], 8'h00, 1'b0);
          add_result(RES_TX, {6'b0, len[9:8]}, 8'h00, 1'b0);
          if (len == 10'd0) begin
            add_trailer();
          end else begin
            link_phase = LINK_PAYLOAD;
          end
        end
      end
      OP_PAYLOAD: begin
        if (link_phase != LINK_PAYLOAD || bytes_left == 10'd0) begin
          add_result(RES_ERROR, 8'h00, 8'h00, 1'b0);
        end else begin
          add_result(RES_TX, db, 8'h00, 1'b0);
          checksum   = checksum + 16'(db);
          bytes_left = bytes_left - 10'd1;
          if (bytes_left == 10'd0) add_trailer();
        end
      end
      OP_RX: begin
        if (link_phase == LINK_RX1) begin
          link_phase = LINK_RX2;
        end else if (link_phase == LINK_RX2) begin
          add_result(RES_STATUS, 8'h00, db, db != STATUS_ABSENT);
          link_phase = LINK_IDLE;
        end else begin
          add_result(RES_ERROR, 8'h00, 8'h00, 1'b0);
        end
      end
      default: begin
        add_result(RES_ABORT, 8'h00, 8'h00, 1'b0);
        link_phase = LINK_IDLE;
        bytes_left = 10'd0;
      end
    endcase
    if (expected_results_q.size() > queued) begin
      expected_results_q[expected_results_q.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void check_field(string field, logic [7:0] exp_val,
                                      logic [7:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, field, exp_val, act_val);
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_results_q.delete();
      link_phase       = LINK_IDLE;
      bytes_left       = 10'd0;
      checksum         = 16'h0000;
      errors           = 0;
      mismatch_count_o <= 0;
      outstanding_o    <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_results_q.size() == 0) begin
          $display("%0t: unexpected result transfer, kind 0x%0h tx 0x%0h",
                   $time, result_kind_i, tx_byte_i);
          errors++;
        end else begin
          want = expected_results_q.pop_front();
          check_field("result_kind", 8'(want.kind), 8'(result_kind_i));
          check_field("tx_byte", want.tx, tx_byte_i);
          check_field("status_byte", want.status, status_byte_i);
          check_field("printer_present", 8'(want.present), 8'(printer_present_i));
          check_field("last_of_run", 8'(want.last), 8'(last_of_run_i));
        end
      end
      if (push && !full) begin
        frame_item(opcode_e'(opcode_i), command_i, payload_length_i, data_byte_i);
      end
      mismatch_count_o <= errors;
      outstanding_o    <= expected_results_q.size();
    end
  end

endmodule

/* dv/tb_printer_packet_framer.sv */
// ----------------------------------------------------------------------------
// tb_printer_packet_framer
// Drives directed and random printer packets, protocol violations and link
// failures into the framer with bursty input and a stalling result side; the
// checker instance predicts and compares every result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_printer_packet_framer;
  import ppf_pkg::*;

  localparam int TOTAL_ITEMS  = 370;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 160;
  localparam int HOLD_PERIOD  = 1200;
  localparam int DRAIN_CYCLES = 20;

  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       push             = 1'b0;
  logic       full;
  logic [1:0] opcode_i         = OP_FAIL;
  logic [7:0] command_i        = 8'h00;
  logic [9:0] payload_length_i = 10'd0;
  logic [7:0] data_byte_i      = 8'h00;
  logic       empty;
  logic       pop              = 1'b0;
  logic [1:0] result_kind_o;
  logic [7:0] tx_byte_o;
  logic [7:0] status_byte_o;
  logic       printer_present_o;
  logic       last_of_run_o;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  int burst_left  = 0;
  int items_sent  = 0;

  printer_packet_framer u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .opcode_i         (opcode_i),
    .command_i        (command_i),
    .payload_length_i (payload_length_i),
    .data_byte_i      (data_byte_i),
    .empty            (empty),
    .pop              (pop),
    .result_kind_o    (result_kind_o),
    .tx_byte_o        (tx_byte_o),
    .status_byte_o    (status_byte_o),
    .printer_present_o(printer_present_o),
    .last_of_run_o    (last_of_run_o)
  );

  ppf_framer_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .opcode_i         (opcode_i),
    .command_i        (command_i),
    .payload_length_i (payload_length_i),
    .data_byte_i      (data_byte_i),
    .empty            (empty),
    .pop              (pop),
    .result_kind_i    (result_kind_o),
    .tx_byte_i        (tx_byte_o),
    .status_byte_i    (status_byte_o),
    .printer_present_i(printer_present_o),
    .last_of_run_i    (last_of_run_o),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [9:0] rnd10();
    return 10'($urandom_range(0, 1023));
  endfunction

  // one transfer into the framer, with burst gaps in front of it
  task automatic send_item(opcode_e op, logic [7:0] cmd, logic [9:0] len,
                           logic [7:0] db);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    push             <= 1'b1;
    opcode_i         <= op;
    command_i        <= cmd;
    payload_length_i <= len;
    data_byte_i      <= db;
    do @(posedge clk_i); while (full);
    burst_left--;
    items_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // heavy packets carry no injected faults so the wrapped checksum goes out
  task automatic send_packet(logic [9:0] len, bit heavy);
    int r;
    send_item(OP_START, rnd8(), len, rnd8());
    if (len > MAX_PAYLOAD) return;
    for (int i = 0; i < int'(len); i++) begin
      r = heavy ? 99 : $urandom_range(0, 99);
      if (r < 2) begin
        send_item(OP_FAIL, rnd8(), rnd10(), rnd8());
        return;
      end
      if (r < 5) send_item((r < 4) ? OP_START : OP_RX, rnd8(), rnd10(), rnd8());
      send_item(OP_PAYLOAD, rnd8(), rnd10(),
                heavy ? 8'($urandom_range(240, 255)) : rnd8());
    end
    r = heavy ? 99 : $urandom_range(0, 99);
    if (r < 4) begin
      send_item(OP_FAIL, rnd8(), rnd10(), rnd8());
      return;
    end
    if (r < 8) send_item(OP_PAYLOAD, rnd8(), rnd10(), rnd8());
    send_item(OP_RX, rnd8(), rnd10(), rnd8());
    send_item(OP_RX, rnd8(), rnd10(),
              ($urandom_range(0, 3) == 0) ? STATUS_ABSENT : rnd8());
  endtask

  // result side: random stall pattern plus a long hold-off now and then
  initial begin : receiver
    int mode;
    int run_len;
    int elapsed;
    int next_hold;
    elapsed   = 0;
    next_hold = 400;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (elapsed >= next_hold) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        elapsed   += HOLD_CYCLES;
        next_hold = elapsed + HOLD_PERIOD;
      end
      mode    = $urandom_range(0, 2);
      run_len = $urandom_range(1, 16);
      repeat (run_len) begin
        case (mode)
          0:       pop <= 1'b1;
          1:       pop <= 1'($urandom_range(0, 1));
          default: pop <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk_i);
        elapsed++;
      end
    end
  end

  initial begin : stimulus
    int  r;
    bit  wrap_done;
    bit  pause_done;
    logic [9:0] len;
    wrap_done  = 1'b0;
    pause_done = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sequence errors and abort while idle, oversize starts
    send_item(OP_RX, 8'h00, 10'd0, 8'h5A);
    send_item(OP_PAYLOAD, 8'h00, 10'd0, 8'hFF);
    send_item(OP_FAIL, 8'h00, 10'd0, 8'h00);
    send_item(OP_START, 8'hFF, 10'd641, 8'h00);
    send_item(OP_START, 8'h00, 10'd1023, 8'hFF);
    // empty packet, then busy start and payload while awaiting reply
    send_item(OP_START, 8'hA5, 10'd0, 8'h00);
    send_item(OP_START, 8'h01, 10'd1, 8'h00);
    send_item(OP_PAYLOAD, 8'h00, 10'd0, 8'h11);
    send_item(OP_RX, 8'h00, 10'd0, 8'h12);
    send_item(OP_RX, 8'h00, 10'd0, STATUS_ABSENT);
    // maximum length, aborted partway
    send_item(OP_START, 8'hFF, 10'd640, 8'h00);
    send_item(OP_PAYLOAD, 8'h00, 10'd0, 8'hFF);
    send_item(OP_PAYLOAD, 8'h00, 10'd0, 8'h00);
    send_item(OP_START, 8'h00, 10'd0, 8'h00);
    send_item(OP_RX, 8'h00, 10'd0, 8'h00);
    send_item(OP_FAIL, 8'hFF, 10'h3FF, 8'hFF);
    // a complete packet with a present printer, then one aborted before its reply
    send_item(OP_START, 8'h5A, 10'd2, 8'h00);
    send_item(OP_PAYLOAD, 8'h00, 10'd0, 8'h80);
    send_item(OP_PAYLOAD, 8'h00, 10'd0, 8'h7F);
    send_item(OP_RX, 8'h00, 10'd0, 8'h00);
    send_item(OP_RX, 8'h00, 10'd0, 8'h00);
    send_item(OP_START, 8'h3C, 10'd1, 8'h00);
    send_item(OP_PAYLOAD, 8'h00, 10'd0, 8'hC3);
    send_item(OP_RX, 8'h00, 10'd0, 8'hAA);
    send_item(OP_FAIL, 8'h00, 10'd0, 8'h00);
    wait_drained();

    while (items_sent < TOTAL_ITEMS) begin
      if (!wrap_done && items_sent >= 30) begin
        // long payload of large bytes so the checksum is likely to wrap
        send_packet(10'($urandom_range(270, 300)), 1'b1);
        wrap_done = 1'b1;
      end else if (!pause_done && items_sent >= 320) begin
        wait_drained();
        pause_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          r = $urandom_range(0, 99);
          if (r < 15)      len = 10'd0;
          else if (r < 85) len = 10'($urandom_range(1, 6));
          else             len = 10'($urandom_range(7, 30));
          send_packet(len, 1'b0);
        end else if (r < 74) begin
          send_packet(10'($urandom_range(MAX_PAYLOAD + 1, 1023)), 1'b0);
        end else if (r < 77) begin
          send_item(OP_START, rnd8(), 10'($urandom_range(513, MAX_PAYLOAD)), rnd8());
          repeat ($urandom_range(1, 3)) send_item(OP_PAYLOAD, rnd8(), rnd10(), rnd8());
          send_item(OP_FAIL, rnd8(), rnd10(), rnd8());
        end else begin
          r = $urandom_range(0, 3);
          if (r == int'(OP_START)) begin
            len = ($urandom_range(0, 1) == 0) ?
                  10'($urandom_range(MAX_PAYLOAD + 1, 1023)) :
                  10'($urandom_range(0, 3));
          end else begin
            len = rnd10();
          end
          send_item(opcode_e'(r), rnd8(), len, rnd8());
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/ppf_pkg.sv
rtl/core/ppf_front.sv
rtl/core/ppf_queue.sv
rtl/core/ppf_back.sv
rtl/core/printer_packet_framer.sv
dv/ppf_framer_checker.sv
dv/tb_printer_packet_framer.sv
